@@ design/sfr_pkg.sv @@
// shared types, constants and helpers for the stream find and replace block
package sfr_pkg;

    localparam int MAX_PATTERN     = 16;
    localparam int MAX_REPLACEMENT = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    typedef logic [7:0]            byte_t;
    typedef logic [4:0]            len_t;
    typedef logic [3:0]            pos_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_PATTERN_LENGTH      = 3'd0;
    localparam cfg_idx_t REG_PATTERN_BYTES_LOW   = 3'd1;
    localparam cfg_idx_t REG_PATTERN_BYTES_HIGH  = 3'd2;
    localparam cfg_idx_t REG_REPLACE_LENGTH      = 3'd3;
    localparam cfg_idx_t REG_REPLACE_BYTES_LOW   = 3'd4;
    localparam cfg_idx_t REG_REPLACE_BYTES_HIGH  = 3'd5;

    function automatic len_t clamp_len(len_t v, len_t maxv);
        len_t r;
        if (v == 5'd0)
        begin
            r = 5'd1;
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic byte_t pick_byte(cfg_data_t lo, cfg_data_t hi, pos_t i);
        byte_t r;
        if (i[3])
        begin
            r = hi[{i[2:0], 3'b000} +: 8];
        end
        else
        begin
            r = lo[{i[2:0], 3'b000} +: 8];
        end
        return r;
    endfunction

endpackage

@@ design/sfr_ifs.sv @@
// valid/ready channel interfaces for input bytes, output bytes and config writes
interface sfr_in_if;
    import sfr_pkg::*;
    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  stream_end;
    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface sfr_out_if;
    import sfr_pkg::*;
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  run_last;
    logic  output_end;
    modport source (output valid, output out_byte, output run_last, output output_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input output_end,
                    output ready);
endinterface

interface sfr_cfg_if;
    import sfr_pkg::*;
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/stream_find_replace_core.sv @@
// stream find and replace core: sequencer around one shared prefix compare unit
//
//  channel | dir | payload                          | beat
//  --------+-----+----------------------------------+------------------------------
//  cfg     | in  | index, data                      | register write, always ready
//  din     | in  | in_byte, stream_end              | one source byte
//  dout    | out | out_byte, run_last, output_end   | one rewritten byte
//
// a byte is accepted in S_IDLE, then compared in S_SCAN, which releases front bytes
// until the final compare; S_REPL or S_FLUSH emit bytes and S_FIN closes the byte
// one emitted byte waits in a pending register so run_last is known when it leaves
// din.ready is low from accept through the closing cycle; dout stalls hold the sequencer
// reset clears control and config; the held byte buffer is not cleared
module stream_find_replace_core
(
    input  logic     clk,
    input  logic     rst_n,
    sfr_cfg_if.sink  cfg,
    sfr_in_if.sink   din,
    sfr_out_if.source dout
);
    import sfr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_REPL  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    len_t       pat_len_reg, rep_len_reg;
    cfg_data_t  pat_lo_reg, pat_hi_reg, rep_lo_reg, rep_hi_reg;

    byte_t      buf_reg [MAX_PATTERN];
    byte_t      buf_next [MAX_PATTERN];
    len_t       cnt_reg, cnt_next;
    logic       first_reg, first_next;
    logic       end_reg, end_next;
    pos_t       idx_reg, idx_next;

    logic       pend_valid_reg, pend_valid_next;
    byte_t      pend_byte_reg, pend_byte_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       out_end_reg, out_end_next;

    len_t       plen, rlen;
    logic       eq, full, keep;
    logic       slot_free, can_emit, emit_req;
    byte_t      emit_byte;

    assign plen = clamp_len(pat_len_reg, len_t'(MAX_PATTERN));
    assign rlen = clamp_len(rep_len_reg, len_t'(MAX_REPLACEMENT));

    // prefix compare of the held buffer against the pattern over cnt bytes
    always_comb
    begin
        eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((len_t'(i) < cnt_reg) &&
                (buf_reg[i] != pick_byte(pat_lo_reg, pat_hi_reg, pos_t'(i))))
            begin
                eq = 1'b0;
            end
        end
    end

    assign full = first_reg && (cnt_reg == plen) && eq;
    assign keep = (cnt_reg < plen) && eq;

    assign slot_free = !out_valid_reg || dout.ready;
    assign can_emit  = !pend_valid_reg || slot_free;

    assign cfg.ready = 1'b1;
    assign din.ready = (state_reg == S_IDLE);

    assign dout.valid      = out_valid_reg;
    assign dout.out_byte   = out_byte_reg;
    assign dout.run_last   = out_last_reg;
    assign dout.output_end = out_end_reg;

    always_comb
    begin
        state_next      = state_reg;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg && !dout.ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;
        emit_req        = 1'b0;
        emit_byte       = buf_reg[0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    buf_next[cnt_reg[3:0]] = din.in_byte;
                    cnt_next   = cnt_reg + 5'd1;
                    end_next   = din.stream_end;
                    first_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (full)
                begin
                    cnt_next   = 5'd0;
                    idx_next   = 4'd0;
                    state_next = S_REPL;
                end
                else if (keep)
                begin
                    if (end_reg && (cnt_reg != 5'd0))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    emit_req = 1'b1;
                    if (can_emit)
                    begin
                        for (int i = 0; i < MAX_PATTERN - 1; i++)
                        begin
                            buf_next[i] = buf_reg[i+1];
                        end
                        cnt_next   = cnt_reg - 5'd1;
                        first_next = 1'b0;
                    end
                end
            end
            S_REPL:
            begin
                emit_req  = 1'b1;
                emit_byte = pick_byte(rep_lo_reg, rep_hi_reg, idx_reg);
                if (can_emit)
                begin
                    idx_next = idx_reg + 4'd1;
                    if ((len_t'({1'b0, idx_reg}) + 5'd1) == rlen)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FLUSH:
            begin
                emit_req = 1'b1;
                if (can_emit)
                begin
                    for (int i = 0; i < MAX_PATTERN - 1; i++)
                    begin
                        buf_next[i] = buf_reg[i+1];
                    end
                    cnt_next = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = pend_byte_reg;
                    out_last_next   = 1'b1;
                    out_end_next    = end_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pending byte moves to the output when the next one arrives
        if (emit_req && can_emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_last_next  = 1'b0;
                out_end_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= 5'd0;
            first_reg      <= 1'b0;
            end_reg        <= 1'b0;
            idx_reg        <= 4'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pat_len_reg    <= 5'd1;
            pat_lo_reg     <= '0;
            pat_hi_reg     <= '0;
            rep_len_reg    <= 5'd1;
            rep_lo_reg     <= '0;
            rep_hi_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            first_reg      <= first_next;
            end_reg        <= end_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_PATTERN_LENGTH:     pat_len_reg <= cfg.data[4:0];
                    REG_PATTERN_BYTES_LOW:  pat_lo_reg  <= cfg.data;
                    REG_PATTERN_BYTES_HIGH: pat_hi_reg  <= cfg.data;
                    REG_REPLACE_LENGTH:     rep_len_reg <= cfg.data[4:0];
                    REG_REPLACE_BYTES_LOW:  rep_lo_reg  <= cfg.data;
                    REG_REPLACE_BYTES_HIGH: rep_hi_reg  <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg       <= buf_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_end_reg   <= out_end_next;
    end

endmodule

@@ design/sfr_checker.sv @@
// port level checks for the stream find and replace core, with its bind
module sfr_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_run_last,
    input logic out_output_end,
    input logic cfg_ready
);

    // a stalled output beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // one byte at a time: input closes right after an accepted beat
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a byte is in work");

    // end of text is always the last beat of its byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_output_end |-> out_run_last)
        else $error("output_end without run_last");

    // config port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind stream_find_replace_core sfr_checker u_sfr_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (din.valid),
    .in_ready       (din.ready),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready),
    .out_run_last   (dout.run_last),
    .out_output_end (dout.output_end),
    .cfg_ready      (cfg.ready)
);

@@ verif/tb.sv @@
// testbench for stream_find_replace_core: rewritten byte stream checked beat by beat against a predictor
`timescale 1ns / 100ps

module tb;
    import sfr_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_BYTES = 425;
    localparam int PHASES       = 10;

    typedef struct packed {
        byte_t out_byte;
        logic  run_last;
        logic  output_end;
    } result_t;

    typedef byte_t span_t [0:16];

    logic clk;
    logic rst_n;

    sfr_cfg_if cfg_bus ();
    sfr_in_if  din_bus ();
    sfr_out_if dout_bus ();

    stream_find_replace_core u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .din   (din_bus),
        .dout  (dout_bus)
    );

    // predictor copy of the rule registers and the held prefix
    len_t         pattern_len_reg;
    len_t         replace_len_reg;
    logic [127:0] pattern_word;
    logic [127:0] replace_word;
    byte_t        held [0:15];
    int           held_n;

    result_t expected_text [$];
    byte_t   symbols [0:2];
    int      error_count;
    int      bytes_sent;
    int      stuck_cycles;
    bit      sender_idle_on;
    bit      sink_stall_on;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int eff_len(len_t v, int maxv);
        if (v == 5'd0)
        begin
            return 1;
        end
        if (int'(v) > maxv)
        begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic bit is_prefix(span_t s, int head, int m);
        int i;
        for (i = 0; i < m; i++)
        begin
            if (s[head + i] != pattern_word[8*i +: 8])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void rewrite_byte(byte_t b, logic e);
        span_t   s;
        byte_t   emitted [$];
        int      n;
        int      head;
        int      plen;
        int      rlen;
        int      i;
        result_t r;
        plen = eff_len(pattern_len_reg, MAX_PATTERN);
        rlen = eff_len(replace_len_reg, MAX_REPLACEMENT);
        for (i = 0; i < held_n; i++)
        begin
            s[i] = held[i];
        end
        n = held_n;
        s[n] = b;
        n++;
        if (n == plen && is_prefix(s, 0, n))
        begin
            for (i = 0; i < rlen; i++)
            begin
                emitted.push_back(replace_word[8*i +: 8]);
            end
            held_n = 0;
        end
        else
        begin
            head = 0;
            while (head < n)
            begin
                if (n - head < plen && is_prefix(s, head, n - head))
                begin
                    break;
                end
                emitted.push_back(s[head]);
                head++;
            end
            held_n = n - head;
            for (i = 0; i < held_n; i++)
            begin
                held[i] = s[head + i];
            end
        end
        if (e)
        begin
            for (i = 0; i < held_n; i++)
            begin
                emitted.push_back(held[i]);
            end
            held_n = 0;
        end
        for (i = 0; i < emitted.size(); i++)
        begin
            r.out_byte   = emitted[i];
            r.run_last   = (i == emitted.size() - 1);
            r.output_end = e && (i == emitted.size() - 1);
            expected_text.push_back(r);
        end
    endfunction

    task automatic push_source_byte(byte_t b, logic e);
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            din_bus.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        din_bus.valid      = 1'b1;
        din_bus.in_byte    = b;
        din_bus.stream_end = e;
        @(posedge clk);
        while (!din_bus.ready)
        begin
            @(posedge clk);
        end
        rewrite_byte(b, e);
        bytes_sent++;
        @(negedge clk);
        din_bus.valid = 1'b0;
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_data_t d);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = d;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_PATTERN_LENGTH:     pattern_len_reg = d[4:0];
            REG_PATTERN_BYTES_LOW:  pattern_word[63:0] = d;
            REG_PATTERN_BYTES_HIGH: pattern_word[127:64] = d;
            REG_REPLACE_LENGTH:     replace_len_reg = d[4:0];
            REG_REPLACE_BYTES_LOW:  replace_word[63:0] = d;
            REG_REPLACE_BYTES_HIGH: replace_word[127:64] = d;
            default:                ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // wait for every expected beat, then let a byte with no output finish
    task automatic settle();
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_rule(cfg_data_t plen, cfg_data_t plo, cfg_data_t phi,
                             cfg_data_t rlen, cfg_data_t rlo, cfg_data_t rhi);
        settle();
        write_reg(REG_PATTERN_LENGTH, plen);
        write_reg(REG_PATTERN_BYTES_LOW, plo);
        write_reg(REG_PATTERN_BYTES_HIGH, phi);
        write_reg(REG_REPLACE_LENGTH, rlen);
        write_reg(REG_REPLACE_BYTES_LOW, rlo);
        write_reg(REG_REPLACE_BYTES_HIGH, rhi);
    endtask

    task automatic test_reset_rule();
        push_source_byte(8'h00, 1'b0);
        push_source_byte(8'hFF, 1'b1);
    endtask

    task automatic test_length_limits();
        // zero pattern length acts as one, oversized replacement saturates
        load_rule(64'hFFFF_FFFF_FFFF_FFE0, 64'h0000_0000_0000_00FF, 64'h0,
                  64'd31, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        push_source_byte(8'hFF, 1'b0);
        push_source_byte(8'h7E, 1'b1);
        // oversized pattern length saturates to a full sixteen byte pattern
        load_rule(64'd31, 64'h00FF_5AA5_C33C_9669, 64'hF00F_0FF0_817E_18E7,
                  64'd1, 64'h0000_0000_0000_00AA, 64'h0);
        for (int i = 0; i < 16; i++)
        begin
            push_source_byte(pattern_word[8*i +: 8], i == 15);
        end
    endtask

    task automatic test_held_prefix();
        load_rule(64'd3, 64'h0000_0000_0063_6261, 64'h0,
                  64'd2, 64'h0000_0000_0000_5958, 64'h0);
        push_source_byte(8'h61, 1'b0);
        push_source_byte(8'h62, 1'b0);
        // pattern swapped while a prefix is still held
        load_rule(64'd2, 64'h0000_0000_0000_7162, 64'h0,
                  64'd3, 64'h0000_0000_005A_5A5A, 64'h0);
        push_source_byte(8'h62, 1'b0);
        push_source_byte(8'h71, 1'b1);
    endtask

    task automatic load_random_rule();
        logic [127:0] pw;
        cfg_data_t    plen_d;
        cfg_data_t    rlen_d;
        int           pick;
        int           j;
        for (j = 0; j < 3; j++)
        begin
            symbols[j] = byte_t'($urandom_range(0, 255));
        end
        plen_d = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            plen_d[4:0] = 5'd0;
        end
        else if (pick == 1)
        begin
            plen_d[4:0] = len_t'($urandom_range(17, 31));
        end
        else if (pick == 2)
        begin
            plen_d[4:0] = 5'd16;
        end
        else if (pick < 15)
        begin
            plen_d[4:0] = len_t'($urandom_range(1, 4));
        end
        else
        begin
            plen_d[4:0] = len_t'($urandom_range(1, 16));
        end
        pw = {$urandom, $urandom, $urandom, $urandom};
        for (j = 0; j < eff_len(plen_d[4:0], MAX_PATTERN); j++)
        begin
            pw[8*j +: 8] = symbols[$urandom_range(0, 2)];
        end
        rlen_d = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            rlen_d[4:0] = 5'd0;
        end
        else if (pick == 1)
        begin
            rlen_d[4:0] = len_t'($urandom_range(17, 31));
        end
        else
        begin
            rlen_d[4:0] = len_t'($urandom_range(1, 16));
        end
        load_rule(plen_d, pw[63:0], pw[127:64], rlen_d,
                  {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic test_random_rules();
        int ph;
        int goal;
        int span;
        int plen;
        int pick;
        int j;
        for (ph = 0; ph < PHASES; ph++)
        begin
            load_random_rule();
            sender_idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
            sink_stall_on  = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
            goal = bytes_sent + RANDOM_BYTES / PHASES;
            plen = eff_len(pattern_len_reg, MAX_PATTERN);
            while (bytes_sent < goal)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 10)
                begin
                    span = $urandom_range(0, 1) ? plen : $urandom_range(1, plen);
                    for (j = 0; j < span; j++)
                    begin
                        push_source_byte(pattern_word[8*j +: 8], $urandom_range(0, 29) == 0);
                    end
                end
                else if (pick < 17)
                begin
                    push_source_byte(symbols[$urandom_range(0, 2)], $urandom_range(0, 29) == 0);
                end
                else
                begin
                    push_source_byte(byte_t'($urandom_range(0, 255)),
                                     $urandom_range(0, 29) == 0);
                end
            end
        end
    endtask

    initial
    begin : sink_pacing
        int hold;
        hold = 0;
        dout_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                dout_bus.ready = 1'b0;
            end
            else if (sink_stall_on && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(0, 4);
                dout_bus.ready = 1'b0;
            end
            else
            begin
                dout_bus.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_beat
        result_t want;
        if (rst_n && dout_bus.valid && dout_bus.ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected beat out_byte %0h", dout_bus.out_byte);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (dout_bus.out_byte !== want.out_byte)
                begin
                    $error("out_byte expected %0h actual %0h", want.out_byte,
                           dout_bus.out_byte);
                    error_count++;
                end
                if (dout_bus.run_last !== want.run_last)
                begin
                    $error("run_last expected %0b actual %0b", want.run_last,
                           dout_bus.run_last);
                    error_count++;
                end
                if (dout_bus.output_end !== want.output_end)
                begin
                    $error("output_end expected %0b actual %0b", want.output_end,
                           dout_bus.output_end);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("stream_find_replace_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        din_bus.valid      = 1'b0;
        din_bus.in_byte    = 8'h00;
        din_bus.stream_end = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_PATTERN_LENGTH;
        cfg_bus.data       = '0;
        pattern_len_reg    = 5'd1;
        replace_len_reg    = 5'd1;
        pattern_word       = '0;
        replace_word       = '0;
        held_n             = 0;
        error_count        = 0;
        bytes_sent         = 0;
        stuck_cycles       = 0;
        sender_idle_on     = 1'b1;
        sink_stall_on      = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_rule();
        test_length_limits();
        test_held_prefix();
        test_random_rules();

        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("stream_find_replace_core: match");
        end
        else
        begin
            $display("stream_find_replace_core: mismatch");
        end
        $finish;
    end

endmodule
